@@ rtl/core/frq_pkg.sv @@
// Shared types, constants and helpers for the quarter-turn frame rotator.
// Depends on nothing; used by frq_store and frame_rotate_quarter_turns_unit.
`default_nettype none

package frq_pkg;

  localparam int MAX_WIDTH      = 64;
  localparam int MAX_HEIGHT     = 64;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int LOAD_BITS   = $clog2(STORE_DEPTH + 1);
  localparam int DIM_BITS    = 7;
  localparam int POS_BITS    = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 7;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_QUARTER_TURNS = 2'd2,
    CFG_TURN_LEFT     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    TURN_NONE    = 2'd0,
    TURN_QUARTER = 2'd1,
    TURN_HALF    = 2'd2,
    TURN_THREE   = 2'd3
  } turn_e;

  typedef struct packed {
    logic                 wr_en;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] addr;
  } store_req_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] out_width;
    logic [DIM_BITS-1:0] out_height;
    logic                row_end;
    logic                last;
  } beat_meta_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] maxv);
    logic [DIM_BITS-1:0] res;
    res = v;
    if (v == '0) res = DIM_BITS'(1);
    else if (v > maxv) res = maxv;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/frame_rotate_quarter_turns_unit.sv @@
// Quarter-turn frame rotator top level: config registers, address generation, output stage.
// Depends on frq_pkg and frq_store.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------------
//  in       | sink      | in_valid_i/in_stall_o | op_i, pixel_in_i
//  out      | source    | out_valid_o/out_stall_i | pixel_out_o, out_width_o, out_height_o,
//           |           |                       | row_end_o, last_o
//  cfg      | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat per cycle on the input side while in_stall_o is low; a read beat is captured at
// acceptance in the frame store read register, then moves to the output register once that
// register is free (not holding a stalled beat).
// Loads produce no output beat. Reset sets the config registers to 64, 64, 0, 0 and
// clears the counters; frame store contents stay unknown until loaded.
// in_stall_o rises only when the memory read stage and the output register are both full
// and the output is stalled.
`default_nettype none

module frame_rotate_quarter_turns_unit #(
  parameter int PIXEL_BITS = frq_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               op_i,
  input  wire logic [PIXEL_BITS-1:0]              pixel_in_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [PIXEL_BITS-1:0]              pixel_out_o,
  output logic      [frq_pkg::DIM_BITS-1:0]       out_width_o,
  output logic      [frq_pkg::DIM_BITS-1:0]       out_height_o,
  output logic                                    row_end_o,
  output logic                                    last_o,

  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [frq_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [frq_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int DB = frq_pkg::DIM_BITS;
  localparam int PB = frq_pkg::POS_BITS;
  localparam int AB = frq_pkg::ADDR_BITS;
  localparam int LB = frq_pkg::LOAD_BITS;

  logic [DB-1:0] image_width_q, image_height_q;
  logic [1:0]    quarter_turns_q;
  logic          turn_left_q;

  logic [LB-1:0] load_cnt_q, load_cnt_d;
  logic [PB-1:0] out_row_q, out_row_d, out_col_q, out_col_d;

  logic                s1_valid_q;
  frq_pkg::beat_meta_t s1_meta_q, s1_meta_d;
  logic                out_valid_q;
  frq_pkg::beat_meta_t out_meta_q;
  logic [PIXEL_BITS-1:0] out_pix_q;

  logic                in_accept, ld_accept, rd_accept, out_free, s1_move;
  logic [DB-1:0]       w, h, ow, oh;
  logic [LB-1:0]       total, load_pos, load_inc;
  frq_pkg::turn_e      turns;
  logic                stale, row_end, last;
  logic [PB-1:0]       r, c, w_m1, h_m1, src_r, src_c;
  logic [AB-1:0]       rd_addr;
  frq_pkg::store_req_t store_req;
  logic [PIXEL_BITS-1:0] store_rdata;

  assign cfg_ready_o = 1'b1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ld_accept  = in_accept && (frq_pkg::op_e'(op_i) == frq_pkg::OP_LOAD);
  assign rd_accept  = in_accept && (frq_pkg::op_e'(op_i) == frq_pkg::OP_READ);

  always_comb begin
    w = frq_pkg::clamp_dim(image_width_q, DB'(frq_pkg::MAX_WIDTH));
    h = frq_pkg::clamp_dim(image_height_q, DB'(frq_pkg::MAX_HEIGHT));
    total = LB'(w) * LB'(h);

    load_pos = (load_cnt_q >= total) ? '0 : load_cnt_q;
    load_inc = load_pos + LB'(1);

    turns = frq_pkg::turn_e'(turn_left_q ? 2'(2'd0 - quarter_turns_q) : quarter_turns_q);
    ow = turns[0] ? h : w;
    oh = turns[0] ? w : h;

    stale = (DB'(out_row_q) >= oh) || (DB'(out_col_q) >= ow);
    r = stale ? '0 : out_row_q;
    c = stale ? '0 : out_col_q;
    w_m1 = PB'(w - DB'(1));
    h_m1 = PB'(h - DB'(1));

    case (turns)
      frq_pkg::TURN_QUARTER: begin
        src_r = h_m1 - c;
        src_c = r;
      end
      frq_pkg::TURN_HALF: begin
        src_r = h_m1 - r;
        src_c = w_m1 - c;
      end
      frq_pkg::TURN_THREE: begin
        src_r = c;
        src_c = w_m1 - r;
      end
      default: begin
        src_r = r;
        src_c = c;
      end
    endcase
    rd_addr = AB'(src_r) * AB'(w) + AB'(src_c);

    row_end = (DB'(c) + DB'(1)) == ow;
    last    = row_end && ((DB'(r) + DB'(1)) == oh);

    s1_meta_d.out_width  = ow;
    s1_meta_d.out_height = oh;
    s1_meta_d.row_end    = row_end;
    s1_meta_d.last       = last;

    load_cnt_d = load_cnt_q;
    if (ld_accept) begin
      load_cnt_d = (load_inc >= total) ? '0 : load_inc;
    end

    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (rd_accept) begin
      if (row_end) begin
        out_col_d = '0;
        out_row_d = last ? '0 : PB'(r + PB'(1));
      end else begin
        out_row_d = r;
        out_col_d = PB'(c + PB'(1));
      end
    end

    store_req.wr_en = ld_accept;
    store_req.rd_en = rd_accept;
    store_req.addr  = ld_accept ? AB'(load_pos) : rd_addr;
  end

  frq_store #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .req_i  (store_req),
    .wdata_i(pixel_in_i),
    .rdata_o(store_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= DB'(64);
      image_height_q  <= DB'(64);
      quarter_turns_q <= 2'd0;
      turn_left_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (frq_pkg::cfg_idx_e'(cfg_index_i))
        frq_pkg::CFG_IMAGE_WIDTH:   image_width_q   <= DB'(cfg_data_i);
        frq_pkg::CFG_IMAGE_HEIGHT:  image_height_q  <= DB'(cfg_data_i);
        frq_pkg::CFG_QUARTER_TURNS: quarter_turns_q <= cfg_data_i[1:0];
        frq_pkg::CFG_TURN_LEFT:     turn_left_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      load_cnt_q <= load_cnt_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      if (rd_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_accept) begin
      s1_meta_q <= s1_meta_d;
    end
    if (s1_move) begin
      out_meta_q <= s1_meta_q;
      out_pix_q  <= store_rdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = out_pix_q;
  assign out_width_o  = out_meta_q.out_width;
  assign out_height_o = out_meta_q.out_height;
  assign row_end_o    = out_meta_q.row_end;
  assign last_o       = out_meta_q.last;

  a_read_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_accept |=> s1_valid_q)
    else $error("accepted read did not reach the memory read stage");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_meta_q)))
    else $error("blocked read stage lost or changed its beat");

  a_last_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> row_end_o)
    else $error("frame end beat without row end");

  a_load_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_accept && !s1_valid_q) |=> !s1_valid_q)
    else $error("load produced an output beat");

endmodule

`default_nettype wire

@@ rtl/core/frq_store.sv @@
// Frame store: single-port synchronous pixel memory with registered read data.
// Depends on frq_pkg for the request struct and depth.
`default_nettype none

module frq_store #(
  parameter int PIXEL_BITS = frq_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire frq_pkg::store_req_t   req_i,
  input  wire logic [PIXEL_BITS-1:0] wdata_i,
  output logic      [PIXEL_BITS-1:0] rdata_o
);

  logic [PIXEL_BITS-1:0] mem_q [frq_pkg::STORE_DEPTH];
  logic [PIXEL_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= wdata_i;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sim/frame_rotate_quarter_turns_unit_test.sv @@
// Self-checking testbench for frame_rotate_quarter_turns_unit: loads frames, reads them back
// rotated and compares every output beat with an in-bench rotation predictor.
// Depends on frq_pkg and the frame_rotate_quarter_turns_unit RTL.
module frame_rotate_quarter_turns_unit_test;

  localparam int          CLK_PERIOD      = 10;
  localparam int          PIX_BITS        = frq_pkg::PIXEL_BITS_DEF;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned RANDOM_ITEMS    = 440;

  typedef struct packed {
    frq_pkg::op_e        op;
    logic [PIX_BITS-1:0] pixel;
  } rot_request_t;

  typedef struct packed {
    logic [PIX_BITS-1:0]          pixel;
    logic [frq_pkg::DIM_BITS-1:0] width;
    logic [frq_pkg::DIM_BITS-1:0] height;
    logic                         row_end;
    logic                         last;
  } rotated_pixel_t;

  logic                              clk_i  = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic                              op_i = 1'b0;
  logic [PIX_BITS-1:0]               pixel_in_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [PIX_BITS-1:0]               pixel_out_o;
  logic [frq_pkg::DIM_BITS-1:0]      out_width_o;
  logic [frq_pkg::DIM_BITS-1:0]      out_height_o;
  logic                              row_end_o;
  logic                              last_o;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [frq_pkg::CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [frq_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;

  frame_rotate_quarter_turns_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .out_width_o  (out_width_o),
    .out_height_o (out_height_o),
    .row_end_o    (row_end_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predictor state: register shadow, frame store and the load / readout positions.
  logic [6:0]          cfg_width  = 7'd64;
  logic [6:0]          cfg_height = 7'd64;
  logic [1:0]          cfg_turns  = 2'd0;
  logic                cfg_left   = 1'b0;
  logic [PIX_BITS-1:0] frame_mem [frq_pkg::STORE_DEPTH];
  bit                  frame_written [frq_pkg::STORE_DEPTH];
  int unsigned         load_ptr = 0;
  int unsigned         read_row = 0;
  int unsigned         read_col = 0;

  rot_request_t   pending_q[$];
  rotated_pixel_t result_q[$];
  rot_request_t   next_req;
  rotated_pixel_t want;
  int unsigned    queued_items = 0;
  int             mismatch_count = 0;
  int unsigned    in_gap = 0;
  int unsigned    stall_left = 0;
  int unsigned    stuck_cycles = 0;
  bit             in_calm = 1'b0;
  bit             out_calm = 1'b0;

  function automatic int unsigned fit_dim(input logic [6:0] v, input int unsigned limit);
    if (v == 7'd0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [6:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 14) return 7'($urandom_range(64, 127));
    return 7'($urandom_range(1, 9));
  endfunction

  function automatic bit region_written(input int unsigned total);
    for (int unsigned a = 0; a < total; a++) begin
      if (!frame_written[a]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic rotate_predict(input frq_pkg::op_e op, input logic [PIX_BITS-1:0] pix);
    int unsigned    w, h, total, ow, oh, src_r, src_c;
    logic [1:0]     turn_amt;
    frq_pkg::turn_e turns;
    rotated_pixel_t beat;
    w = fit_dim(cfg_width, frq_pkg::MAX_WIDTH);
    h = fit_dim(cfg_height, frq_pkg::MAX_HEIGHT);
    total = w * h;
    if (op == frq_pkg::OP_LOAD) begin
      if (load_ptr >= total) load_ptr = 0;
      frame_mem[load_ptr] = pix;
      frame_written[load_ptr] = 1'b1;
      load_ptr = load_ptr + 1;
      if (load_ptr >= total) load_ptr = 0;
    end else begin
      turn_amt = cfg_left ? 2'd0 - cfg_turns : cfg_turns;
      turns = frq_pkg::turn_e'(turn_amt);
      if (turns == frq_pkg::TURN_QUARTER || turns == frq_pkg::TURN_THREE) begin
        ow = h;
        oh = w;
      end else begin
        ow = w;
        oh = h;
      end
      if (read_row >= oh || read_col >= ow) begin
        read_row = 0;
        read_col = 0;
      end
      case (turns)
        frq_pkg::TURN_QUARTER: begin
          src_r = h - 1 - read_col;
          src_c = read_row;
        end
        frq_pkg::TURN_HALF: begin
          src_r = h - 1 - read_row;
          src_c = w - 1 - read_col;
        end
        frq_pkg::TURN_THREE: begin
          src_r = read_col;
          src_c = w - 1 - read_row;
        end
        default: begin
          src_r = read_row;
          src_c = read_col;
        end
      endcase
      beat.pixel   = frame_mem[src_r * w + src_c];
      beat.width   = frq_pkg::DIM_BITS'(ow);
      beat.height  = frq_pkg::DIM_BITS'(oh);
      beat.row_end = (read_col + 1 == ow);
      beat.last    = beat.row_end && (read_row + 1 == oh);
      if (beat.row_end) begin
        read_col = 0;
        read_row = beat.last ? 0 : read_row + 1;
      end else begin
        read_col = read_col + 1;
      end
      result_q.push_back(beat);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Input driver: present queued beats, hold them while stalled, insert random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i       <= frq_pkg::OP_LOAD;
      pixel_in_i <= '0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) rotate_predict(frq_pkg::op_e'(op_i), pixel_in_i);
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= in_gap - 1;
        end else if (pending_q.size() != 0) begin
          next_req = pending_q.pop_front();
          in_valid_i <= 1'b1;
          op_i       <= next_req.op;
          pixel_in_i <= next_req.pixel;
          in_gap     <= idle_len(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check accepted beats in order, apply random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, actual pixel %0h",
                   $time, pixel_out_o);
          mismatch_count++;
        end else begin
          want = result_q.pop_front();
          check_field("pixel_out", want.pixel, pixel_out_o);
          check_field("out_width", want.width, out_width_o);
          check_field("out_height", want.height, out_height_o);
          check_field("row_end", want.row_end, row_end_o);
          check_field("last", want.last, last_o);
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= idle_len(out_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, stuck_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_req(input frq_pkg::op_e op, input logic [PIX_BITS-1:0] pix);
    rot_request_t req;
    req.op    = op;
    req.pixel = pix;
    pending_q.push_back(req);
    queued_items++;
  endtask

  task automatic load_frame(input int unsigned n);
    repeat (n) push_req(frq_pkg::OP_LOAD, PIX_BITS'($urandom_range(0, 255)));
  endtask

  task automatic read_out(input int unsigned n);
    repeat (n) push_req(frq_pkg::OP_READ, PIX_BITS'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input frq_pkg::cfg_idx_e idx, input logic [6:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      frq_pkg::CFG_IMAGE_WIDTH:   cfg_width  = data;
      frq_pkg::CFG_IMAGE_HEIGHT:  cfg_height = data;
      frq_pkg::CFG_QUARTER_TURNS: cfg_turns  = data[1:0];
      default:                    cfg_left   = data[0];
    endcase
  endtask

  task automatic configure(input logic [6:0] w_reg, input logic [6:0] h_reg,
                           input frq_pkg::turn_e qt, input bit left,
                           output int unsigned total);
    settle();
    write_reg(frq_pkg::CFG_IMAGE_WIDTH, w_reg);
    write_reg(frq_pkg::CFG_IMAGE_HEIGHT, h_reg);
    write_reg(frq_pkg::CFG_QUARTER_TURNS, {5'($urandom_range(0, 31)), qt});
    write_reg(frq_pkg::CFG_TURN_LEFT, {6'($urandom_range(0, 63)), left});
    total = fit_dim(w_reg, frq_pkg::MAX_WIDTH) * fit_dim(h_reg, frq_pkg::MAX_HEIGHT);
  endtask

  initial begin
    int unsigned    total;
    int unsigned    phase;
    logic [6:0]     w_reg;
    logic [6:0]     h_reg;
    frq_pkg::turn_e qt;
    bit             left;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero dimensions count as one; the second load wraps onto the same pixel.
    configure(7'd0, 7'd0, frq_pkg::TURN_NONE, 1'b0, total);
    push_req(frq_pkg::OP_LOAD, 8'h00);
    push_req(frq_pkg::OP_LOAD, 8'hFF);
    read_out(2);
    // Wrap the load pointer and stop readout mid-frame.
    configure(7'd3, 7'd2, frq_pkg::TURN_QUARTER, 1'b0, total);
    load_frame(total + 1);
    read_out(total - 1);
    // Readout position falls outside the smaller image.
    configure(7'd2, 7'd2, frq_pkg::TURN_HALF, 1'b1, total);
    read_out(total);
    // Load pointer falls outside the single-pixel image.
    configure(7'd1, 7'd1, frq_pkg::TURN_THREE, 1'b1, total);
    push_req(frq_pkg::OP_LOAD, 8'hFF);
    read_out(1);

    queued_items = 0;
    phase = 0;
    while (queued_items < RANDOM_ITEMS) begin
      if (phase < 8) begin
        qt   = frq_pkg::turn_e'(phase[1:0]);
        left = phase[2];
      end else begin
        qt   = frq_pkg::turn_e'($urandom_range(0, 3));
        left = 1'($urandom_range(0, 1));
      end
      w_reg = pick_dim();
      h_reg = pick_dim();
      if (fit_dim(w_reg, frq_pkg::MAX_WIDTH) * fit_dim(h_reg, frq_pkg::MAX_HEIGHT) > 256)
        h_reg = 7'($urandom_range(1, 4));
      configure(w_reg, h_reg, qt, left, total);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      if (!region_written(total) || $urandom_range(0, 2) != 0) load_frame(total);
      case ($urandom_range(0, 3))
        0:       read_out($urandom_range(1, total));
        1:       read_out(total + $urandom_range(1, total));
        default: read_out(total);
      endcase
      repeat ($urandom_range(0, 8))
        push_req(frq_pkg::op_e'($urandom_range(0, 1)), PIX_BITS'($urandom_range(0, 255)));
      phase++;
    end

    // Full-width row with an oversized width value.
    configure(7'd127, 7'd1, frq_pkg::turn_e'($urandom_range(0, 3)),
              1'($urandom_range(0, 1)), total);
    in_calm  = 1'b0;
    out_calm = 1'b0;
    load_frame(total);
    read_out(total);

    settle();
    if (mismatch_count == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
